// File: design/sdh_pkg.sv
// Package for the SD card SPI host sequencer: phase codes, status codes,
// item kinds, register indexes and the command byte function. No dependencies.
package sdh_pkg;

    localparam int BLOCK_BYTES = 512;
    localparam int BLK_AW = $clog2(BLOCK_BYTES);

    typedef enum logic [5:0] {
        PH_IDLE, PH_PRECLK, PH_DESEL, PH_RESEL, PH_C0, PH_R0, PH_MIDCLK, PH_C8,
        PH_R8, PH_R7SKIP, PH_C55, PH_R55, PH_GAP55, PH_C41, PH_R41, PH_GAP41,
        PH_RPUMP, PH_C17, PH_R17, PH_TOKEN, PH_RDATA, PH_RTAIL, PH_WPUMP, PH_C24,
        PH_R24, PH_WGAP, PH_WSTART, PH_WDATA, PH_WCRC, PH_WRESP, PH_WBUSY, PH_WTAIL
    } t_phase;

    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_RX    = 2'd1;
    localparam logic [1:0] KIND_LOAD  = 2'd2;

    localparam logic [1:0] OP_INIT  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NORESP   = 3'd1;
    localparam logic [2:0] ST_REJECT   = 3'd2;
    localparam logic [2:0] ST_BADTOK   = 3'd3;
    localparam logic [2:0] ST_TOKTMO   = 3'd4;
    localparam logic [2:0] ST_WINTR    = 3'd5;
    localparam logic [2:0] ST_DREJECT  = 3'd6;

    localparam logic [1:0] REG_DUMMY = 2'd0;
    localparam logic [1:0] REG_RST   = 2'd1;
    localparam logic [1:0] REG_RESP  = 2'd2;
    localparam logic [1:0] REG_TOKEN = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  operation;
        logic [31:0] block_address;
        logic [7:0]  card_byte;
        logic [8:0]  load_index;
        logic [7:0]  load_byte;
    } t_in;

    typedef struct packed {
        logic        send_valid;
        logic [7:0]  send_byte;
        logic        chip_select;
        logic        fast_clock;
        logic        read_valid;
        logic [7:0]  read_byte;
        logic [8:0]  read_index;
        logic        done_res;
        logic [2:0]  status;
        logic [1:0]  card_version;
    } t_out;

    // Byte pos of the six-byte command frame for a command phase
    function automatic logic [7:0] cmd_byte(t_phase ph, logic [2:0] pos, logic [31:0] addr);
        logic [7:0] first;
        logic [7:0] b;
        unique case (ph)
            PH_C0:   first = 8'h40;
            PH_C8:   first = 8'h48;
            PH_C55:  first = 8'h77;
            PH_C41:  first = 8'h69;
            PH_C17:  first = 8'h51;
            default: first = 8'h58;
        endcase
        b = 8'h00;
        if (pos == 3'd0) begin
            b = first;
        end else if (pos == 3'd5) begin
            b = (ph == PH_C0) ? 8'h95 : 8'hFF;
        end else if (ph == PH_C17 || ph == PH_C24) begin
            unique case (pos)
                3'd1:    b = addr[31:24];
                3'd2:    b = addr[23:16];
                3'd3:    b = addr[15:8];
                default: b = addr[7:0];
            endcase
        end else if (ph == PH_C8) begin
            b = (pos == 3'd3) ? 8'h01 : ((pos == 3'd4) ? 8'hAA : 8'h00);
        end
        return b;
    endfunction

endpackage

// File: design/sdh_if.sv
// Valid/ready channel carrying one payload item.
// Uses no package.
interface sdh_if #(parameter int W = 8) (input logic i_clk);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/sdh_wbuf.sv
// Write buffer RAM: one write port, one registered read port.
// Depends on sdh_pkg for the block size.
module sdh_wbuf (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [sdh_pkg::BLK_AW-1:0] i_waddr,
    input  logic [7:0]               i_wdata,
    input  logic                     i_re,
    input  logic [sdh_pkg::BLK_AW-1:0] i_raddr,
    output logic [7:0]               o_rdata
);
    logic [7:0] r_mem [sdh_pkg::BLOCK_BYTES];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end
    assign o_rdata = r_rdata;
endmodule

// File: design/sd_card_spi_host_sequencer.sv
// SD card SPI-mode host sequencer.
// Channels: input items (kind, operation, block_address, card_byte, load_index,
// load_byte) on i_in; one result item per start taken in idle or byte received while busy, on o_out.
// Load items write the 512-byte write buffer and give no result.
// An accepted item is held in a decode stage while the write buffer
// RAM is read (one synchronous read port, byte at the next data position);
// once the output register is free, the result goes into it and is offered
// on o_out. Loads are forwarded over that read when they hit the
// same entry. Throughput is one item per cycle when the output side keeps up.
// The output register is a single stage; while it holds an untaken result
// the block still accepts one more item into its decode stage, and stalls
// input only when both stages are full.
// Reset (synchronous, active low) returns to idle, version 1, slow clock,
// and the default register values; the buffer contents stay undefined.
// Configuration writes are taken any cycle on i_cfg_we.
module sd_card_spi_host_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sdh_if.sink         i_in,
    sdh_if.source       o_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    // configuration registers
    logic [15:0] r_dummy;
    logic [7:0]  r_rst_tries;
    logic [7:0]  r_resp_tries;
    logic [15:0] r_tok_tries;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dummy      <= 16'd10000;
            r_rst_tries  <= 8'd100;
            r_resp_tries <= 8'd10;
            r_tok_tries  <= 16'd32767;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sdh_pkg::REG_DUMMY: r_dummy      <= i_cfg_data;
                sdh_pkg::REG_RST:   r_rst_tries  <= i_cfg_data[7:0];
                sdh_pkg::REG_RESP:  r_resp_tries <= i_cfg_data[7:0];
                default:            r_tok_tries  <= i_cfg_data;
            endcase
        end
    end

    // sequencer state
    sdh_pkg::t_phase r_phase;
    logic [15:0] r_cnt;
    logic [15:0] r_tries;
    logic [2:0]  r_pos;
    logic [31:0] r_addr;
    logic [1:0]  r_ver;
    logic        r_fast;

    // decode stage
    logic         r_s1_v;
    sdh_pkg::t_in r_s1;
    logic [7:0]   r_fwd_byte;
    logic         r_fwd_hit;

    // output stage
    logic          r_o_v;
    sdh_pkg::t_out r_o;

    logic s1_go, in_acc;
    assign s1_go  = r_s1_v && (!r_o_v || o_out.ready);
    assign i_in.ready = !r_s1_v || s1_go;
    assign in_acc = i_in.valid && i_in.ready;
    assign o_out.valid = r_o_v;
    assign o_out.data  = r_o;

    sdh_pkg::t_in in_d;
    assign in_d = sdh_pkg::t_in'(i_in.data);

    // buffer read address: data position the accepted item needs next
    logic [sdh_pkg::BLK_AW-1:0] rd_addr, cnt_next_pos;
    logic [7:0] buf_rdata;
    logic       s1_load;
    logic       s1_rx;
    assign s1_load = s1_go && (r_s1.kind == sdh_pkg::KIND_LOAD);
    assign s1_rx   = s1_go && (r_s1.kind == sdh_pkg::KIND_RX);
    // position for the next data byte, taking an in-flight item into account
    always_comb begin
        cnt_next_pos = r_cnt[sdh_pkg::BLK_AW-1:0] + 1'b1;
        if (s1_rx) begin
            if (r_phase == sdh_pkg::PH_WSTART)
                cnt_next_pos = sdh_pkg::BLK_AW'(1);
            else if (r_phase == sdh_pkg::PH_WDATA)
                cnt_next_pos = r_cnt[sdh_pkg::BLK_AW-1:0] + 2'd2;
        end
        if (s1_rx && r_phase == sdh_pkg::PH_WGAP)
            rd_addr = '0;
        else if (!s1_rx && r_phase == sdh_pkg::PH_WSTART)
            rd_addr = '0;
        else
            rd_addr = cnt_next_pos;
    end

    sdh_wbuf u_wbuf (
        .i_clk  (i_clk),
        .i_we   (s1_load),
        .i_waddr(r_s1.load_index),
        .i_wdata(r_s1.load_byte),
        .i_re   (in_acc),
        .i_raddr(rd_addr),
        .o_rdata(buf_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (in_acc) begin
            r_s1_v <= 1'b1;
        end else if (s1_go) begin
            r_s1_v <= 1'b0;
        end
        if (in_acc) begin
            r_s1 <= in_d;
            r_fwd_hit  <= s1_load && (r_s1.load_index == rd_addr);
            r_fwd_byte <= r_s1.load_byte;
        end else if (s1_load && r_s1_v) begin
            r_fwd_hit <= 1'b0;
        end
    end

    // a load in decode stage 1 that hits the entry being read by the held item
    logic [7:0] wbyte;
    assign wbyte = r_fwd_hit ? r_fwd_byte : buf_rdata;

    // next-state and result logic
    sdh_pkg::t_phase n_phase;
    logic [15:0] n_cnt, n_tries;
    logic [2:0]  n_pos;
    logic [31:0] n_addr;
    logic [1:0]  n_ver;
    logic        n_fast;
    sdh_pkg::t_out res;
    logic        emit;
    logic [7:0]  b;
    logic [7:0]  ntr;

    always_comb begin
        n_phase = r_phase; n_cnt = r_cnt; n_tries = r_tries; n_pos = r_pos;
        n_addr = r_addr; n_ver = r_ver; n_fast = r_fast;
        res = '0; emit = 1'b0;
        b = r_s1.card_byte;
        ntr = 8'd0;
        if (r_s1.kind == sdh_pkg::KIND_START && r_phase == sdh_pkg::PH_IDLE
                && r_s1.operation != 2'd3) begin
            emit = 1'b1;
            res.send_valid = 1'b1; res.send_byte = 8'hFF; res.chip_select = 1'b1;
            if (r_s1.operation == sdh_pkg::OP_INIT) begin
                n_fast = 1'b0;
                if (r_dummy == 16'd0) begin
                    n_phase = sdh_pkg::PH_DESEL; res.chip_select = 1'b0;
                end else begin
                    n_phase = sdh_pkg::PH_PRECLK; n_cnt = r_dummy - 16'd1;
                end
            end else begin
                n_addr = r_s1.block_address;
                n_phase = (r_s1.operation == sdh_pkg::OP_READ) ?
                          sdh_pkg::PH_RPUMP : sdh_pkg::PH_WPUMP;
            end
        end else if (r_s1.kind == sdh_pkg::KIND_RX && r_phase != sdh_pkg::PH_IDLE) begin
            emit = 1'b1;
            res.send_valid = 1'b1; res.send_byte = 8'hFF; res.chip_select = 1'b1;
            unique case (r_phase)
                sdh_pkg::PH_PRECLK, sdh_pkg::PH_MIDCLK: begin
                    if (r_cnt != 16'd0) begin
                        n_cnt = r_cnt - 16'd1;
                    end else if (r_phase == sdh_pkg::PH_PRECLK) begin
                        n_phase = sdh_pkg::PH_DESEL; res.chip_select = 1'b0;
                    end else begin
                        n_phase = sdh_pkg::PH_C8; n_pos = 3'd0;
                        res.send_byte = sdh_pkg::cmd_byte(sdh_pkg::PH_C8, 3'd0, r_addr);
                    end
                end
                sdh_pkg::PH_DESEL: n_phase = sdh_pkg::PH_RESEL;
                sdh_pkg::PH_RESEL, sdh_pkg::PH_GAP55, sdh_pkg::PH_RPUMP,
                sdh_pkg::PH_WPUMP: begin
                    unique case (r_phase)
                        sdh_pkg::PH_RESEL: n_phase = sdh_pkg::PH_C0;
                        sdh_pkg::PH_GAP55: n_phase = sdh_pkg::PH_C41;
                        sdh_pkg::PH_RPUMP: n_phase = sdh_pkg::PH_C17;
                        default:           n_phase = sdh_pkg::PH_C24;
                    endcase
                    n_pos = 3'd0;
                    res.send_byte = sdh_pkg::cmd_byte(n_phase, 3'd0, r_addr);
                end
                sdh_pkg::PH_C0, sdh_pkg::PH_C8, sdh_pkg::PH_C55, sdh_pkg::PH_C41,
                sdh_pkg::PH_C17, sdh_pkg::PH_C24: begin
                    if (r_pos < 3'd5) begin
                        n_pos = r_pos + 3'd1;
                        res.send_byte = sdh_pkg::cmd_byte(r_phase, n_pos, r_addr);
                    end else begin
                        ntr = (r_phase == sdh_pkg::PH_C0) ? r_rst_tries : r_resp_tries;
                        n_tries = (ntr == 8'd0) ? 16'd1 : {8'd0, ntr};
                        n_phase = sdh_pkg::t_phase'(r_phase + 6'd1);
                    end
                end
                sdh_pkg::PH_R0, sdh_pkg::PH_R8, sdh_pkg::PH_R55, sdh_pkg::PH_R41,
                sdh_pkg::PH_R17, sdh_pkg::PH_R24: begin
                    if (b == 8'hFF && r_tries > 16'd1) begin
                        n_tries = r_tries - 16'd1;
                    end else begin
                        priority case (r_phase)
                            sdh_pkg::PH_R0: begin
                                if (b == 8'hFF) begin
                                    n_phase = sdh_pkg::PH_IDLE; emit = 1'b1;
                                    res = '0; res.done_res = 1'b1;
                                    res.status = sdh_pkg::ST_NORESP;
                                end else if (r_dummy == 16'd0) begin
                                    n_phase = sdh_pkg::PH_C8; n_pos = 3'd0;
                                    res.send_byte = sdh_pkg::cmd_byte(sdh_pkg::PH_C8,
                                                                      3'd0, r_addr);
                                end else begin
                                    n_phase = sdh_pkg::PH_MIDCLK; n_cnt = r_dummy - 16'd1;
                                end
                            end
                            sdh_pkg::PH_R8: begin
                                if (!b[7]) begin
                                    n_cnt = 16'd3; n_phase = sdh_pkg::PH_R7SKIP;
                                end else begin
                                    n_ver = 2'd1; n_phase = sdh_pkg::PH_C55; n_pos = 3'd0;
                                    res.send_byte = sdh_pkg::cmd_byte(sdh_pkg::PH_C55,
                                                                      3'd0, r_addr);
                                end
                            end
                            sdh_pkg::PH_R55: n_phase = sdh_pkg::PH_GAP55;
                            sdh_pkg::PH_R41: begin
                                if (b == 8'hFF) begin
                                    n_phase = sdh_pkg::PH_IDLE;
                                    res = '0; res.done_res = 1'b1;
                                    res.status = sdh_pkg::ST_NORESP;
                                end else begin
                                    n_cnt = {15'd0, b != 8'd0};
                                    n_phase = sdh_pkg::PH_GAP41;
                                end
                            end
                            default: begin
                                if (b != 8'h00) begin
                                    n_phase = sdh_pkg::PH_IDLE;
                                    res = '0; res.done_res = 1'b1;
                                    res.status = (b == 8'hFF) ? sdh_pkg::ST_NORESP :
                                                 sdh_pkg::ST_REJECT;
                                end else if (r_phase == sdh_pkg::PH_R17) begin
                                    n_tries = (r_tok_tries == 16'd0) ? 16'd1 : r_tok_tries;
                                    n_phase = sdh_pkg::PH_TOKEN;
                                end else begin
                                    n_phase = sdh_pkg::PH_WGAP;
                                end
                            end
                        endcase
                    end
                end
                sdh_pkg::PH_R7SKIP: begin
                    if (r_cnt != 16'd0) begin
                        n_cnt = r_cnt - 16'd1;
                    end else begin
                        n_ver = (b == 8'hAA) ? 2'd2 : 2'd1;
                        n_phase = sdh_pkg::PH_C55; n_pos = 3'd0;
                        res.send_byte = sdh_pkg::cmd_byte(sdh_pkg::PH_C55, 3'd0, r_addr);
                    end
                end
                sdh_pkg::PH_GAP41: begin
                    if (r_cnt != 16'd0) begin
                        n_phase = sdh_pkg::PH_C55; n_pos = 3'd0;
                        res.send_byte = sdh_pkg::cmd_byte(sdh_pkg::PH_C55, 3'd0, r_addr);
                    end else begin
                        n_fast = 1'b1; n_phase = sdh_pkg::PH_IDLE;
                        res = '0; res.done_res = 1'b1; res.status = sdh_pkg::ST_OK;
                    end
                end
                sdh_pkg::PH_TOKEN: begin
                    if (b == 8'hFE) begin
                        n_cnt = 16'd0; n_phase = sdh_pkg::PH_RDATA;
                    end else if (b != 8'hFF) begin
                        n_phase = sdh_pkg::PH_IDLE;
                        res = '0; res.done_res = 1'b1; res.status = sdh_pkg::ST_BADTOK;
                    end else if (r_tries > 16'd1) begin
                        n_tries = r_tries - 16'd1;
                    end else begin
                        n_phase = sdh_pkg::PH_IDLE;
                        res = '0; res.done_res = 1'b1; res.status = sdh_pkg::ST_TOKTMO;
                    end
                end
                sdh_pkg::PH_RDATA: begin
                    res.read_valid = 1'b1; res.read_byte = b;
                    res.read_index = r_cnt[8:0];
                    if (r_cnt >= 16'(sdh_pkg::BLOCK_BYTES - 1)) begin
                        n_cnt = 16'd2; n_phase = sdh_pkg::PH_RTAIL;
                    end else begin
                        n_cnt = r_cnt + 16'd1;
                    end
                end
                sdh_pkg::PH_RTAIL, sdh_pkg::PH_WCRC: begin
                    if (r_cnt != 16'd0) begin
                        n_cnt = r_cnt - 16'd1;
                        res.send_byte = (r_phase == sdh_pkg::PH_RTAIL) ? 8'hFF : 8'hAA;
                    end else if (r_phase == sdh_pkg::PH_RTAIL) begin
                        n_phase = sdh_pkg::PH_IDLE;
                        res = '0; res.done_res = 1'b1; res.status = sdh_pkg::ST_OK;
                    end else begin
                        n_phase = sdh_pkg::PH_WRESP;
                    end
                end
                sdh_pkg::PH_WGAP: begin
                    n_phase = sdh_pkg::PH_WSTART; res.send_byte = 8'hFE;
                end
                sdh_pkg::PH_WSTART: begin
                    n_cnt = 16'd0; n_phase = sdh_pkg::PH_WDATA; res.send_byte = wbyte;
                end
                sdh_pkg::PH_WDATA: begin
                    if (b != 8'hFF) begin
                        n_phase = sdh_pkg::PH_IDLE;
                        res = '0; res.done_res = 1'b1; res.status = sdh_pkg::ST_WINTR;
                    end else if (r_cnt >= 16'(sdh_pkg::BLOCK_BYTES - 1)) begin
                        n_cnt = 16'd1; n_phase = sdh_pkg::PH_WCRC; res.send_byte = 8'hAA;
                    end else begin
                        n_cnt = r_cnt + 16'd1; res.send_byte = wbyte;
                    end
                end
                sdh_pkg::PH_WRESP: begin
                    if (b[4:0] != 5'h05) begin
                        n_phase = sdh_pkg::PH_IDLE;
                        res = '0; res.done_res = 1'b1; res.status = sdh_pkg::ST_DREJECT;
                    end else begin
                        n_phase = sdh_pkg::PH_WBUSY;
                    end
                end
                sdh_pkg::PH_WBUSY: begin
                    if (b == 8'hFF) n_phase = sdh_pkg::PH_WTAIL;
                end
                default: begin
                    n_phase = sdh_pkg::PH_IDLE;
                    res = '0; res.done_res = 1'b1; res.status = sdh_pkg::ST_OK;
                end
            endcase
        end
        res.fast_clock = n_fast;
        res.card_version = n_ver;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= sdh_pkg::PH_IDLE;
            r_cnt <= '0; r_tries <= '0; r_pos <= '0; r_addr <= '0;
            r_ver <= 2'd1; r_fast <= 1'b0; r_o_v <= 1'b0;
        end else begin
            // result stays while unread, a new one replaces a taken one
            r_o_v <= (r_o_v && !o_out.ready) || (s1_go && emit);
            if (s1_go) begin
                r_phase <= n_phase; r_cnt <= n_cnt; r_tries <= n_tries;
                r_pos <= n_pos; r_addr <= n_addr; r_ver <= n_ver; r_fast <= n_fast;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && emit) r_o <= res;
    end

`ifndef SYNTH
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && emit && res.done_res) |=> (r_phase == sdh_pkg::PH_IDLE))
        else $error("finish left sequencer busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_v && !o_out.ready) |=> (r_o_v && $stable(r_o)))
        else $error("result dropped under stall");
    a_done_nosend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_v |-> !(r_o.done_res && r_o.send_valid))
        else $error("finish carries a send byte");
`endif
endmodule
